// ===== hdl/cbhd_pkg.sv =====
`default_nettype none

package cbhd_pkg;

  // Default width of the remaining-byte counter.
  localparam int unsigned LengthBitsDef = 16;
  // Width of the total_length register as written by software.
  localparam int unsigned CfgW = 16;

  localparam int unsigned OutTdataW = 80;

  // Result kinds (m_axis_tuser).
  localparam logic [1:0] KIND_HEAD  = 2'd0;
  localparam logic [1:0] KIND_TEXT  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_TRUNCATED   = 2'd0;
  localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ERR_SHORT_COUNT = 2'd2;
  localparam logic [1:0] ERR_LENGTH      = 2'd3;

  // Major types handled by the decoder.
  localparam logic [2:0] MT_UINT = 3'd0;
  localparam logic [2:0] MT_NINT = 3'd1;
  localparam logic [2:0] MT_TEXT = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_item;
    logic       last_of_chunk;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  major_type;
    logic [63:0] head_value;
    logic        is_negative;
    logic [7:0]  content_byte;
    logic [1:0]  error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/cbhd_in_stage.sv =====
`default_nettype none

module cbhd_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire cbhd_pkg::in_item_t item_i,
  input  wire logic              advance_i,
  output logic                   valid_o,
  output cbhd_pkg::in_item_t     item_o
);

  logic               valid_q, valid_d;
  cbhd_pkg::in_item_t item_q;

  // The stage is free when empty or when its word moves on this cycle.
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== hdl/cbhd_parse.sv =====
`default_nettype none

module cbhd_parse #(
  parameter int unsigned LENGTH_BITS = cbhd_pkg::LengthBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire cbhd_pkg::in_item_t item_i,
  input  wire logic [((LENGTH_BITS < cbhd_pkg::CfgW) ? LENGTH_BITS : cbhd_pkg::CfgW)-1:0]
                                  total_i,
  output logic                    has_result_o,
  output cbhd_pkg::result_t       result_o
);

  localparam int unsigned TotalW = (LENGTH_BITS < cbhd_pkg::CfgW) ? LENGTH_BITS : cbhd_pkg::CfgW;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ARG  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_ERR  = 2'd3;

  logic [1:0]             phase_q, phase_d;
  logic [2:0]             kind_q, kind_d;
  logic [3:0]             left_q, left_d;
  logic [63:0]            accum_q, accum_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;

  logic                   fin;
  logic                   err;
  logic [1:0]             err_code;
  logic [4:0]             short_count;
  logic [7:0]             b;

  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    left_d       = left_q;
    accum_d      = accum_q;
    rem_d        = rem_q;
    fin          = 1'b0;
    err          = 1'b0;
    err_code     = cbhd_pkg::ERR_TRUNCATED;
    has_result_o = 1'b0;
    result_o     = '0;
    b            = item_i.data_byte;
    short_count  = b[4:0];

    if (item_i.first_of_item) begin
      kind_d  = b[7:5];
      accum_d = '0;
      left_d  = '0;
      rem_d   = '0;
      phase_d = PH_IDLE;
      if (total_i == '0) begin
        err      = 1'b1;
        err_code = cbhd_pkg::ERR_LENGTH;
      end else begin
        rem_d = LENGTH_BITS'(total_i - TotalW'(1));
        if (short_count <= 5'd23) begin
          accum_d = 64'(short_count);
          fin     = 1'b1;
        end else if (short_count <= 5'd27) begin
          left_d  = 4'(1) << short_count[1:0];
          phase_d = PH_ARG;
          if (item_i.last_of_chunk) begin
            err      = 1'b1;
            err_code = cbhd_pkg::ERR_TRUNCATED;
          end
        end else if (short_count == 5'd31) begin
          err      = 1'b1;
          err_code = cbhd_pkg::ERR_UNSUPPORTED;
        end else begin
          err      = 1'b1;
          err_code = cbhd_pkg::ERR_SHORT_COUNT;
        end
      end
    end else begin
      case (phase_q)
        PH_ARG: begin
          if (rem_q == '0) begin
            err      = 1'b1;
            err_code = cbhd_pkg::ERR_LENGTH;
          end else begin
            accum_d = {accum_q[55:0], b};
            rem_d   = rem_q - LENGTH_BITS'(1);
            if (left_q != '0) begin
              left_d = left_q - 4'd1;
            end
            if (left_d == '0) begin
              fin = 1'b1;
            end else if (item_i.last_of_chunk) begin
              err      = 1'b1;
              err_code = cbhd_pkg::ERR_TRUNCATED;
            end
          end
        end
        PH_BODY: begin
          if (rem_q == '0) begin
            err      = 1'b1;
            err_code = cbhd_pkg::ERR_LENGTH;
          end else begin
            rem_d                 = rem_q - LENGTH_BITS'(1);
            has_result_o          = 1'b1;
            result_o.result_kind  = cbhd_pkg::KIND_TEXT;
            result_o.major_type   = cbhd_pkg::MT_TEXT;
            result_o.content_byte = b;
          end
        end
        default: begin
        end
      endcase
    end

    // A complete head is checked against the bytes still to come.
    if (fin) begin
      if (kind_d == cbhd_pkg::MT_UINT || kind_d == cbhd_pkg::MT_NINT) begin
        if (rem_d != '0) begin
          err      = 1'b1;
          err_code = cbhd_pkg::ERR_LENGTH;
        end
      end else if (kind_d == cbhd_pkg::MT_TEXT) begin
        if (accum_d != 64'(rem_d)) begin
          err      = 1'b1;
          err_code = cbhd_pkg::ERR_LENGTH;
        end
      end else begin
        err      = 1'b1;
        err_code = cbhd_pkg::ERR_UNSUPPORTED;
      end
      if (!err) begin
        has_result_o         = 1'b1;
        result_o.result_kind = cbhd_pkg::KIND_HEAD;
        result_o.major_type  = kind_d;
        result_o.head_value  = accum_d;
        result_o.is_negative = (kind_d == cbhd_pkg::MT_NINT);
        phase_d              = PH_BODY;
      end
    end

    if (err) begin
      has_result_o         = 1'b1;
      result_o             = '0;
      result_o.result_kind = cbhd_pkg::KIND_ERROR;
      result_o.major_type  = kind_d;
      result_o.error_code  = err_code;
      phase_d              = PH_ERR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      kind_q  <= '0;
      left_q  <= '0;
      accum_q <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      left_q  <= left_d;
      accum_q <= accum_d;
      rem_q   <= rem_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cbhd_out_reg.sv =====
`default_nettype none

module cbhd_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire cbhd_pkg::result_t result_i,
  input  wire logic              ready_i,
  output logic                   valid_o,
  output cbhd_pkg::result_t      result_o
);

  logic              valid_q, valid_d;
  cbhd_pkg::result_t result_q;

  // Loading is only offered when the register is empty or being drained.
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== hdl/cbor_head_and_text_decoder.sv =====
// Channel | Dir | Handshake               | Payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata: data_byte; tuser: first_of_item;
//         |     |                         | tlast: last_of_chunk
// m_axis  | out | m_axis_tvalid/tready    | tdata: see port; tuser: result_kind
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_data_i: total_length
//
// One byte is taken every cycle while the result register is not stalled; each
// result is registered (input register, then decode into the result register).
// Reset clears the parser to wait for a head byte and sets total_length to 0.
// A stalled result register holds the input register, which then lowers
// s_axis_tready once it is full as well.
`default_nettype none

module cbor_head_and_text_decoder #(
  parameter int unsigned LENGTH_BITS = cbhd_pkg::LengthBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // Input byte stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] first_of_item
  input  wire logic        s_axis_tlast,
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] major_type, [66:3] head_value, [67] is_negative,
  // [75:68] content_byte, [77:76] error_code, [79:78] zero
  output logic [cbhd_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic [1:0]       m_axis_tuser    // [1:0] result_kind
);

  localparam int unsigned TotalW = (LENGTH_BITS < cbhd_pkg::CfgW) ? LENGTH_BITS : cbhd_pkg::CfgW;

  logic [TotalW-1:0]  total_q;
  cbhd_pkg::in_item_t in_item;
  cbhd_pkg::in_item_t stage_item;
  logic               stage_valid;
  logic               advance;
  logic               has_result;
  cbhd_pkg::result_t  parse_result;
  cbhd_pkg::result_t  out_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cfg_valid_i) begin
      total_q <= cfg_data_i[TotalW-1:0];
    end
  end

  assign in_item.data_byte     = s_axis_tdata;
  assign in_item.first_of_item = s_axis_tuser;
  assign in_item.last_of_chunk = s_axis_tlast;

  // A word leaves the input register only when the result register can take
  // whatever it produces.
  assign advance = stage_valid && (!m_axis_tvalid || m_axis_tready);

  cbhd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  cbhd_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (stage_item),
    .total_i      (total_q),
    .has_result_o (has_result),
    .result_o     (parse_result)
  );

  cbhd_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && has_result),
    .result_i (parse_result),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .result_o (out_result)
  );

  assign m_axis_tuser = out_result.result_kind;
  assign m_axis_tdata = {2'b00, out_result.error_code, out_result.content_byte,
                         out_result.is_negative, out_result.head_value,
                         out_result.major_type};

  // A full input register must not be dropped while the result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && m_axis_tvalid && !m_axis_tready |=> stage_valid)
    else $error("input word lost while result stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_result.result_kind == cbhd_pkg::KIND_TEXT |->
      out_result.major_type == cbhd_pkg::MT_TEXT && out_result.head_value == '0)
    else $error("text byte result carries head fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_result.result_kind == cbhd_pkg::KIND_ERROR |->
      out_result.head_value == '0 && out_result.content_byte == '0 &&
      !out_result.is_negative)
    else $error("error result carries data fields");

endmodule

`default_nettype wire
